// File: rtl/intel_hex_record_parser_core_macros.svh
// assertion helpers for the hex parser core
`ifndef INTEL_HEX_RECORD_PARSER_CORE_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define IHX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define IHX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/ihx_pkg.sv
package ihx_pkg;
  localparam int MAX_RECORD_BYTES_DEF = 255;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_EOF  = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_CHAR = 3'd1;
  localparam logic [2:0] ERR_LEN  = 3'd2;
  localparam logic [2:0] ERR_SUM  = 3'd3;
  localparam logic [2:0] ERR_TYPE = 3'd4;

  localparam logic [2:0] CFG_WORD   = 3'd0;
  localparam logic [2:0] CFG_TRIM   = 3'd1;
  localparam logic [2:0] CFG_CSIZE  = 3'd2;
  localparam logic [2:0] CFG_FBASE  = 3'd3;
  localparam logic [2:0] CFG_FSIZE  = 3'd4;
  localparam logic [2:0] CFG_EBASE  = 3'd5;
  localparam logic [2:0] CFG_ESIZE  = 3'd6;

  // front end to back end: one classified event
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [31:0] addr;
    logic [7:0]  data;
  } ihx_evt_t;

  typedef struct packed {
    logic        word_addressed;
    logic        trim_odd_bytes;
    logic [21:0] code_size;
    logic [30:0] config_base;
    logic [10:0] config_size;
    logic [30:0] eeprom_base;
    logic [12:0] eeprom_size;
  } ihx_cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [31:0] addr;
    logic [7:0]  data;
    logic [7:0]  pbyte;
    logic        chit;
    logic [20:0] cidx;
    logic        fhit;
    logic [9:0]  fidx;
    logic        ehit;
    logic [11:0] eidx;
  } ihx_res_t;
endpackage

// File: rtl/intel_hex_record_parser_core.sv
// channel | direction | tdata fields (low bit up)                     | tuser
// in_     | in        | char_in[7:0]                                   | -
// out_    | out       | error_code, abs_address, data_byte, program_byte,| kind
//         |           | code_hit, code_index, config_hit, config_index,  |
//         |           | eeprom_hit, eeprom_index                         |
// cfg_    | in        | write enable, index, 31-bit data                 | -
// one character is accepted per cycle while the queue has room; the parse state is registered.
// a result is registered first in the queue, then in the result register after the address windows.
// reset is synchronous; no clearing pass.
// a stalled output fills the two-entry queue, then in_tready drops.
module intel_hex_record_parser_core import ihx_pkg::*; #(
  parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [103:0] out_tdata, // error_code, abs_address, data_byte, program_byte,
                                  // code_hit, code_index, config_hit, config_index,
                                  // eeprom_hit, eeprom_index, zero fill
  output logic [1:0]  out_tuser,  // kind
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);
`include "intel_hex_record_parser_core_macros.svh"
  ihx_cfg_t cfg_r;
  ihx_evt_t fe_evt, q_evt;
  ihx_res_t res;
  logic fe_valid, room, q_valid, q_take;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else if (cfg_we) begin
      case (cfg_index)
        CFG_WORD:  cfg_r.word_addressed <= cfg_data[0];
        CFG_TRIM:  cfg_r.trim_odd_bytes <= cfg_data[0];
        CFG_CSIZE: cfg_r.code_size <= cfg_data[21:0];
        CFG_FBASE: cfg_r.config_base <= cfg_data;
        CFG_FSIZE: cfg_r.config_size <= cfg_data[10:0];
        CFG_EBASE: cfg_r.eeprom_base <= cfg_data;
        CFG_ESIZE: cfg_r.eeprom_size <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  ihx_front #(.MAX_RECORD_BYTES(MAX_RECORD_BYTES)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .char_in(in_tdata), .room,
    .in_ready(in_tready), .evt_valid(fe_valid), .evt(fe_evt)
  );

  ihx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .wr_en(fe_valid), .wr_data(fe_evt), .room,
    .rd_valid(q_valid), .rd_en(q_take), .rd_data(q_evt)
  );

  ihx_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .evt_valid(q_valid), .evt(q_evt), .evt_take(q_take),
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tuser = res.kind;
  assign out_tdata = {7'd0, res.eidx, res.ehit, res.fidx, res.fhit, res.cidx, res.chit,
                      res.pbyte, res.data, res.addr, res.err};

  `IHX_ASSERT_IMP(a_ok_no_err, out_tvalid && out_tuser != KIND_ERR, out_tdata[2:0] == ERR_NONE,
    "non-error result carries an error code")
  `IHX_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
    "stalled result changed")
  `IHX_ASSERT_IMP(a_no_overrun, fe_valid, room, "queue written while full")
endmodule

// File: rtl/ihx_front.sv
module ihx_front import ihx_pkg::*; #(
  parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] char_in,
  input  logic       room,
  output logic       in_ready,
  output logic       evt_valid,
  output ihx_evt_t   evt
);
  typedef enum logic [7:0] {
    PH_WAIT = 8'b0000_0001, PH_COUNT = 8'b0000_0010, PH_AHI = 8'b0000_0100,
    PH_ALO = 8'b0000_1000, PH_TYPE = 8'b0001_0000, PH_DATA = 8'b0010_0000,
    PH_CSUM = 8'b0100_0000, PH_AFTER = 8'b1000_0000
  } ph_t;

  ph_t ph_r, ph_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic        pend_r, pend_nxt, halt_r, halt_nxt;
  logic [7:0]  cnt_r, cnt_nxt, typ_r, typ_nxt, off_r, off_nxt, sum_r, sum_nxt;
  logic [7:0]  e0_r, e0_nxt, e1_r, e1_nxt;
  logic [15:0] addr_r, addr_nxt, up_r, up_nxt;
  logic        ws, isx, take;
  logic [3:0]  nib;
  logic [7:0]  b, sum_b, off_inc;

  assign in_ready = room;
  assign take = in_valid && room;
  assign ws = char_in == 8'h20 || (char_in >= 8'd9 && char_in <= 8'd13);

  always_comb begin
    isx = 1'b1;
    nib = 4'd0;
    if (char_in >= "0" && char_in <= "9") nib = 4'(char_in - "0");
    else if (char_in >= "A" && char_in <= "F") nib = 4'(char_in - "A" + 8'd10);
    else if (char_in >= "a" && char_in <= "f") nib = 4'(char_in - "a" + 8'd10);
    else isx = 1'b0;
  end

  assign b = {hi_r, nib};
  assign sum_b = sum_r + b;
  assign off_inc = off_r + 8'd1;

  always_comb begin
    ph_nxt = ph_r; hi_nxt = hi_r; pend_nxt = pend_r; halt_nxt = halt_r;
    cnt_nxt = cnt_r; typ_nxt = typ_r; off_nxt = off_r; sum_nxt = sum_r;
    e0_nxt = e0_r; e1_nxt = e1_r; addr_nxt = addr_r; up_nxt = up_r;
    evt_valid = 1'b0;
    evt.kind = KIND_ERR; evt.err = ERR_NONE; evt.data = b;
    evt.addr = {up_r, 16'd0} + {16'd0, addr_r} + {24'd0, off_r};
    if (take && !halt_r) begin
      if (ph_r == PH_WAIT) begin
        if (!ws) begin
          if (char_in != ":") begin
            evt_valid = 1'b1; evt.err = ERR_CHAR;
          end else begin
            sum_nxt = 8'd0; off_nxt = 8'd0; pend_nxt = 1'b0; ph_nxt = PH_COUNT;
          end
        end
      end else if (ph_r == PH_AFTER) begin
        if (ws) ph_nxt = PH_WAIT;
        else begin
          evt_valid = 1'b1; evt.err = ERR_LEN;
        end
      end else if (ws) begin
        evt_valid = 1'b1; evt.err = ERR_LEN;
      end else if (!isx) begin
        evt_valid = 1'b1; evt.err = ERR_CHAR;
      end else if (!pend_r) begin
        hi_nxt = nib; pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
        sum_nxt = sum_b;
        case (ph_r)
          PH_COUNT: begin
            cnt_nxt = b;
            if (32'(b) > 32'(MAX_RECORD_BYTES)) begin
              evt_valid = 1'b1; evt.err = ERR_LEN;
            end else ph_nxt = PH_AHI;
          end
          PH_AHI: begin
            addr_nxt = {b, 8'd0}; ph_nxt = PH_ALO;
          end
          PH_ALO: begin
            addr_nxt = {addr_r[15:8], b}; ph_nxt = PH_TYPE;
          end
          PH_TYPE: begin
            typ_nxt = b;
            ph_nxt = (cnt_r != 8'd0) ? PH_DATA : PH_CSUM;
          end
          PH_DATA: begin
            if (typ_r == 8'd4) begin
              if (off_r == 8'd0) e0_nxt = b;
              else if (off_r == 8'd1) e1_nxt = b;
            end
            off_nxt = off_inc;
            if (off_inc >= cnt_r) ph_nxt = PH_CSUM;
            if (typ_r == 8'd0) begin
              evt_valid = 1'b1; evt.kind = KIND_DATA;
            end
          end
          PH_CSUM: begin
            ph_nxt = PH_AFTER;
            evt_valid = 1'b1;
            if (sum_b != 8'd0) evt.err = ERR_SUM;
            else if (typ_r == 8'd0) evt.kind = KIND_OK;
            else if (typ_r == 8'd1) evt.kind = KIND_EOF;
            else if (typ_r != 8'd4) evt.err = ERR_TYPE;
            else if (cnt_r != 8'd2) evt.err = ERR_LEN;
            else begin
              evt.kind = KIND_OK; up_nxt = {e0_r, e1_r};
            end
          end
          default: ph_nxt = PH_WAIT;
        endcase
      end
      if (evt_valid && evt.kind != KIND_DATA && evt.kind != KIND_OK) halt_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_WAIT; hi_r <= '0; pend_r <= 1'b0; halt_r <= 1'b0;
      cnt_r <= '0; typ_r <= '0; off_r <= '0; sum_r <= '0;
      e0_r <= '0; e1_r <= '0; addr_r <= '0; up_r <= '0;
    end else begin
      ph_r <= ph_nxt; hi_r <= hi_nxt; pend_r <= pend_nxt; halt_r <= halt_nxt;
      cnt_r <= cnt_nxt; typ_r <= typ_nxt; off_r <= off_nxt; sum_r <= sum_nxt;
      e0_r <= e0_nxt; e1_r <= e1_nxt; addr_r <= addr_nxt; up_r <= up_nxt;
    end
  end
endmodule

// File: rtl/ihx_queue.sv
module ihx_queue import ihx_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  ihx_evt_t wr_data,
  output logic     room,
  output logic     rd_valid,
  input  logic     rd_en,
  output ihx_evt_t rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  ihx_evt_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_rd;

  assign rd_valid = cnt_r != '0;
  assign do_rd = rd_en && rd_valid;
  // room counts a slot freed in the same cycle
  assign room = (cnt_r != (AW+1)'(DEPTH)) || do_rd;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r; rp_nxt = rp_r; cnt_nxt = cnt_r;
    if (wr_en) wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
    if (do_rd) rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
    if (wr_en && !do_rd) cnt_nxt = cnt_r + (AW+1)'(1);
    else if (!wr_en && do_rd) cnt_nxt = cnt_r - (AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule

// File: rtl/ihx_back.sv
module ihx_back import ihx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ihx_cfg_t cfg,
  input  logic     evt_valid,
  input  ihx_evt_t evt,
  output logic     evt_take,
  output logic     res_valid,
  input  logic     res_ready,
  output ihx_res_t res
);
  ihx_res_t res_r, res_nxt;
  logic     v_r;
  logic [32:0] cb, eb, a, fd, ed;
  logic [22:0] csz;
  logic [10:0] fsz;
  logic [12:0] esz;
  logic chit, fhit, ehit;

  assign res_valid = v_r;
  assign res = res_r;
  assign evt_take = evt_valid && (!v_r || res_ready);

  always_comb begin
    csz = (cfg.code_size > 22'd2097152) ? 23'd2097152 : {1'b0, cfg.code_size};
    fsz = (cfg.config_size > 11'd1024) ? 11'd1024 : cfg.config_size;
    esz = (cfg.eeprom_size > 13'd4096) ? 13'd4096 : cfg.eeprom_size;
    cb = cfg.word_addressed ? {1'b0, cfg.config_base, 1'b0} : {2'b0, cfg.config_base};
    eb = cfg.word_addressed ? {1'b0, cfg.eeprom_base, 1'b0} : {2'b0, cfg.eeprom_base};
    a = {1'b0, evt.addr};
    fd = a - cb;
    ed = a - eb;
    chit = a < {10'd0, csz};
    fhit = (a >= cb) && (fd < {22'd0, fsz});
    if (a < eb) ehit = 1'b0;
    else if (cfg.word_addressed) ehit = !ed[0] && ({1'b0, ed[32:1]} < {20'd0, esz});
    else ehit = ed < {20'd0, esz};

    res_nxt = '0;
    res_nxt.kind = evt.kind;
    res_nxt.err = evt.err;
    if (evt.kind == KIND_DATA) begin
      res_nxt.addr = evt.addr;
      res_nxt.data = evt.data;
      res_nxt.chit = chit;
      res_nxt.cidx = chit ? evt.addr[20:0] : '0;
      res_nxt.fhit = fhit;
      res_nxt.fidx = fhit ? fd[9:0] : '0;
      res_nxt.ehit = ehit;
      res_nxt.eidx = ehit ? (cfg.word_addressed ? ed[12:1] : ed[11:0]) : '0;
      res_nxt.pbyte = (cfg.trim_odd_bytes && ((chit && evt.addr[0]) || (fhit && fd[0])))
                      ? (evt.data & 8'h3F) : evt.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (evt_take) v_r <= 1'b1;
    else if (res_ready) v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (evt_take) res_r <= res_nxt;
  end
endmodule

// File: verif/intel_hex_record_parser_core_test.sv
module intel_hex_record_parser_core_test;
  import ihx_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_SEG  = 8'h02;
  localparam logic [7:0] REC_EXT  = 8'h04;

  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [2:0] {
    PH_WAIT, PH_COUNT, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE, PH_DATA, PH_CSUM, PH_AFTER
  } parse_phase_t;

  typedef enum int {
    END_EOF, END_STRAY, END_NONHEX, END_SPACE, END_GLUED, END_SUM, END_TYPE, END_EXT_LEN
  } ending_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;  // error_code, abs_address, data_byte, program_byte, code_hit,
                            // code_index, config_hit, config_index, eeprom_hit, eeprom_index
  logic [1:0]   out_tuser;  // kind
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = CFG_WORD;
  logic [30:0]  cfg_data = '0;

  intel_hex_record_parser_core dut (.*);

  // parser image
  logic         m_word, m_trim;
  logic [21:0]  m_csize;
  logic [30:0]  m_fbase, m_ebase;
  logic [10:0]  m_fsize;
  logic [12:0]  m_esize;
  parse_phase_t m_phase;
  logic [3:0]   m_hi_nib;
  logic         m_pending_nib, m_halted;
  logic [7:0]   m_count, m_type, m_offset, m_sum, m_ext0, m_ext1;
  logic [15:0]  m_raddr, m_upper;

  logic [7:0] char_q[$];
  logic [7:0] payload[$];
  ihx_res_t   result_q[$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  calm = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;
  int  hold_left = 0;

  initial forever #1 clk = ~clk;

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic void close_record(logic [1:0] kind, logic [2:0] err);
    ihx_res_t r;
    r = '0;
    r.kind = kind;
    r.err = err;
    if (kind != KIND_OK) m_halted = 1'b1;
    result_q.push_back(r);
  endfunction

  function automatic void route_byte(logic [7:0] off, logic [7:0] b);
    ihx_res_t r;
    logic [63:0] addr, csz, fsz, esz, cb, eb, d;
    r = '0;
    addr = (({48'd0, m_upper} << 16) + m_raddr + off) & 64'hFFFF_FFFF;
    csz = m_csize > 22'd2097152 ? 64'd2097152 : 64'(m_csize);
    fsz = m_fsize > 11'd1024 ? 64'd1024 : 64'(m_fsize);
    esz = m_esize > 13'd4096 ? 64'd4096 : 64'(m_esize);
    cb = m_word ? 64'(m_fbase) * 2 : 64'(m_fbase);
    eb = m_word ? 64'(m_ebase) * 2 : 64'(m_ebase);
    r.kind = KIND_DATA;
    r.err = ERR_NONE;
    r.addr = addr[31:0];
    r.data = b;
    r.chit = addr < csz;
    if (r.chit) r.cidx = addr[20:0];
    r.fhit = addr >= cb && addr - cb < fsz;
    if (r.fhit) r.fidx = 10'(addr - cb);
    if (addr >= eb) begin
      d = addr - eb;
      if (m_word) begin
        if (!d[0] && (d >> 1) < esz) begin
          r.ehit = 1'b1;
          r.eidx = 12'(d >> 1);
        end
      end else if (d < esz) begin
        r.ehit = 1'b1;
        r.eidx = 12'(d);
      end
    end
    r.pbyte = (m_trim && ((r.chit && r.cidx[0]) || (r.fhit && r.fidx[0]))) ? (b & 8'h3F) : b;
    result_q.push_back(r);
  endfunction

  function automatic void parse_char(logic [7:0] c);
    int v;
    logic [7:0] b, off;
    if (m_halted) return;
    if (m_phase == PH_WAIT) begin
      if (is_space(c)) return;
      if (c != CH_COLON) begin
        close_record(KIND_ERR, ERR_CHAR);
        return;
      end
      m_sum = 0;
      m_offset = 0;
      m_pending_nib = 0;
      m_phase = PH_COUNT;
      return;
    end
    if (m_phase == PH_AFTER) begin
      if (is_space(c)) m_phase = PH_WAIT;
      else close_record(KIND_ERR, ERR_LEN);
      return;
    end
    if (is_space(c)) begin
      close_record(KIND_ERR, ERR_LEN);
      return;
    end
    v = nibble_of(c);
    if (v < 0) begin
      close_record(KIND_ERR, ERR_CHAR);
      return;
    end
    if (!m_pending_nib) begin
      m_hi_nib = 4'(v);
      m_pending_nib = 1;
      return;
    end
    m_pending_nib = 0;
    b = {m_hi_nib, 4'(v)};
    m_sum = m_sum + b;
    case (m_phase)
      PH_COUNT: begin
        m_count = b;
        if (int'(m_count) > MAX_RECORD_BYTES_DEF) close_record(KIND_ERR, ERR_LEN);
        else m_phase = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        m_raddr = {b, 8'h00};
        m_phase = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        m_raddr[7:0] = b;
        m_phase = PH_TYPE;
      end
      PH_TYPE: begin
        m_type = b;
        m_phase = m_count != 0 ? PH_DATA : PH_CSUM;
      end
      PH_DATA: begin
        off = m_offset;
        if (m_type == REC_EXT) begin
          if (off == 0) m_ext0 = b;
          else if (off == 1) m_ext1 = b;
        end
        m_offset = m_offset + 8'd1;
        if (m_offset >= m_count) m_phase = PH_CSUM;
        if (m_type == REC_DATA) route_byte(off, b);
      end
      PH_CSUM: begin
        m_phase = PH_AFTER;
        if (m_sum != 0) close_record(KIND_ERR, ERR_SUM);
        else if (m_type == REC_DATA) close_record(KIND_OK, ERR_NONE);
        else if (m_type == REC_EOF) close_record(KIND_EOF, ERR_NONE);
        else if (m_type != REC_EXT) close_record(KIND_ERR, ERR_TYPE);
        else if (m_count != 2) close_record(KIND_ERR, ERR_LEN);
        else begin
          m_upper = {m_ext0, m_ext1};
          close_record(KIND_OK, ERR_NONE);
        end
      end
      default: m_phase = PH_WAIT;
    endcase
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) parse_char(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (char_q.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
          in_tvalid <= 1'b1;
          in_tdata <= char_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    ihx_res_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.kind  = out_tuser;
        got.err   = out_tdata[2:0];
        got.addr  = out_tdata[34:3];
        got.data  = out_tdata[42:35];
        got.pbyte = out_tdata[50:43];
        got.chit  = out_tdata[51];
        got.cidx  = out_tdata[72:52];
        got.fhit  = out_tdata[73];
        got.fidx  = out_tdata[83:74];
        got.ehit  = out_tdata[84];
        got.eidx  = out_tdata[96:85];
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction kind=%0d err=%0d addr=%h",
                                         got.kind, got.err, got.addr);
        end else begin
          want = result_q.pop_front();
          if (got.kind !== want.kind || got.err !== want.err || got.addr !== want.addr ||
              got.data !== want.data || got.pbyte !== want.pbyte ||
              got.chit !== want.chit || got.cidx !== want.cidx ||
              got.fhit !== want.fhit || got.fidx !== want.fidx ||
              got.ehit !== want.ehit || got.eidx !== want.eidx) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp kind=%0d err=%0d addr=%h data=%h pb=%h c=%0d/%0d f=%0d/%0d e=%0d/%0d",
                       want.kind, want.err, want.addr, want.data, want.pbyte, want.chit,
                       want.cidx, want.fhit, want.fidx, want.ehit, want.eidx);
              $display("         got kind=%0d err=%0d addr=%h data=%h pb=%h c=%0d/%0d f=%0d/%0d e=%0d/%0d",
                       got.kind, got.err, got.addr, got.data, got.pbyte, got.chit,
                       got.cidx, got.fhit, got.fidx, got.ehit, got.eidx);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || $urandom_range(99) >= 38;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_WORD:  m_word = val[0];
      CFG_TRIM:  m_trim = val[0];
      CFG_CSIZE: m_csize = val[21:0];
      CFG_FBASE: m_fbase = val;
      CFG_FSIZE: m_fsize = val[10:0];
      CFG_EBASE: m_ebase = val;
      CFG_ESIZE: m_esize = val[12:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic word, logic trim, logic [21:0] csize, logic [30:0] fbase,
                           logic [10:0] fsize, logic [30:0] ebase, logic [12:0] esize);
    write_reg(CFG_WORD, 31'(word));
    write_reg(CFG_TRIM, 31'(trim));
    write_reg(CFG_CSIZE, 31'(csize));
    write_reg(CFG_FBASE, fbase);
    write_reg(CFG_FSIZE, 31'(fsize));
    write_reg(CFG_EBASE, ebase);
    write_reg(CFG_ESIZE, 31'(esize));
  endtask

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
  endfunction

  function automatic void put_byte(logic [7:0] b);
    char_q.push_back(hex_digit(b[7:4]));
    char_q.push_back(hex_digit(b[3:0]));
  endfunction

  function automatic void put_gap();
    logic [7:0] ws[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    int n;
    n = $urandom_range(1, 3);
    repeat (n) char_q.push_back(ws[$urandom_range(5)]);
  endfunction

  function automatic logic [7:0] rand_data();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // bytes from payload first, random after; checksum corrupted on request
  function automatic void put_record(logic [7:0] cnt, logic [15:0] raddr, logic [7:0] rtype,
                                     bit corrupt, bit trail);
    logic [7:0] sum, b;
    char_q.push_back(CH_COLON);
    put_byte(cnt);
    put_byte(raddr[15:8]);
    put_byte(raddr[7:0]);
    put_byte(rtype);
    sum = cnt + raddr[15:8] + raddr[7:0] + rtype;
    for (int i = 0; i < cnt; i++) begin
      b = payload.size() > 0 ? payload.pop_front() : rand_data();
      sum += b;
      put_byte(b);
    end
    payload.delete();
    sum = -sum;
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    put_byte(sum);
    if (trail) put_gap();
  endfunction

  function automatic void put_ext(logic [15:0] upper);
    payload = '{upper[15:8], upper[7:0]};
    put_record(8'd2, 16'($urandom), REC_EXT, 0, 1);
  endfunction

  function automatic void put_random_records(int n_chars);
    logic [63:0] cb, eb, t;
    logic [7:0] cnt;
    int stop;
    stop = char_q.size() + n_chars;
    cb = m_word ? 64'(m_fbase) * 2 : 64'(m_fbase);
    eb = m_word ? 64'(m_ebase) * 2 : 64'(m_ebase);
    while (char_q.size() < stop) begin
      case ($urandom_range(3))
        0: t = $urandom_range(m_csize > 22'd2097152 ? 2097160 : int'(m_csize) + 8);
        1: t = cb - 4 + $urandom_range(1040);
        2: t = eb - 4 + $urandom_range(m_word ? 8200 : 4110);
        default: t = $urandom;
      endcase
      if (t[31:16] != m_upper || $urandom_range(9) == 0) put_ext(t[31:16]);
      cnt = $urandom_range(19) == 0 ? 8'($urandom) : 8'($urandom_range(0, 16));
      put_record(cnt, t[15:0], REC_DATA, 0, 1);
    end
  endfunction

  function automatic logic [7:0] stray_char(bit in_record);
    logic [7:0] c;
    do c = 8'($urandom);
    while (is_space(c) || nibble_of(c) >= 0 || (!in_record && c == CH_COLON));
    return c;
  endfunction

  function automatic void put_ending();
    ending_t e;
    logic [7:0] rt;
    e = ending_t'($urandom_range(7));
    case (e)
      END_EOF: put_record(8'($urandom), 16'($urandom), REC_EOF, 0, 0);
      END_STRAY: char_q.push_back(stray_char(0));
      END_NONHEX: begin
        char_q.push_back(CH_COLON);
        repeat ($urandom_range(0, 9)) char_q.push_back(hex_digit(4'($urandom)));
        char_q.push_back($urandom_range(3) == 0 ? CH_COLON : stray_char(1));
      end
      END_SPACE: begin
        char_q.push_back(CH_COLON);
        repeat ($urandom_range(0, 9)) char_q.push_back(hex_digit(4'($urandom)));
        char_q.push_back(8'h20);
      end
      END_GLUED: begin
        put_record(8'd1, 16'($urandom), REC_DATA, 0, 0);
        char_q.push_back($urandom_range(1) ? CH_COLON : 8'($urandom_range(8'h21, 8'hFF)));
      end
      END_SUM: put_record(8'($urandom_range(0, 4)), 16'($urandom), REC_DATA, 1, 0);
      END_TYPE: begin
        do rt = 8'($urandom);
        while (rt == REC_DATA || rt == REC_EOF || rt == REC_EXT);
        if ($urandom_range(1)) rt = REC_SEG;
        put_record(8'($urandom_range(0, 4)), 16'($urandom), rt, 0, 0);
      end
      default: begin
        do rt = 8'($urandom_range(0, 6));
        while (rt == 8'd2);
        put_record(rt, 16'($urandom), REC_EXT, 0, 0);
      end
    endcase
    // the parser is halted from here on; these only toggle the input bits
    repeat (40) char_q.push_back(8'($urandom));
    char_q.push_back(8'hFF);
    char_q.push_back(8'h00);
  endfunction

  task automatic drain();
    while (char_q.size() > 0 || in_tvalid || result_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    m_word = 0; m_trim = 0; m_csize = 0; m_fbase = 0; m_fsize = 0; m_ebase = 0; m_esize = 0;
    m_phase = PH_WAIT; m_hi_nib = 0; m_pending_nib = 0; m_halted = 0;
    m_count = 0; m_type = 0; m_offset = 0; m_sum = 0; m_ext0 = 0; m_ext1 = 0;
    m_raddr = 0; m_upper = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: odd-byte trim, window edges, address wrap, lower case, empty record
    write_all(0, 1, 22'd64, 31'h100, 11'd16, 31'h200, 13'd32);
    put_gap();
    payload = '{8'h00, 8'hFF, 8'hC3, 8'h3F};
    put_record(8'd4, 16'h003E, REC_DATA, 0, 1);
    payload = '{8'hAB, 8'hcd, 8'hEF};
    put_record(8'd3, 16'h00FF, REC_DATA, 0, 1);
    put_record(8'd2, 16'h021F, REC_DATA, 0, 1);
    put_ext(16'hFFFF);
    put_record(8'd4, 16'hFFFE, REC_DATA, 0, 1);
    put_ext(16'h0000);
    put_record(8'd0, 16'h1234, REC_DATA, 0, 1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_all(1, 1, 22'h3FFFFF, 31'h7FFF_FFFF, 11'h7FF, 31'h7FFF_FFFF, 13'h1FFF);
        1: write_all(0, 0, 22'd0, 31'd0, 11'd0, 31'd0, 13'd0);
        2: write_all(1, 0, 22'd2097152, 31'h0010_0000, 11'd1024, 31'h0010_4000, 13'd4096);
        default: write_all($urandom_range(1), $urandom_range(1),
                           $urandom_range(1) ? 22'($urandom_range(4096)) : 22'($urandom),
                           $urandom_range(1) ? 31'($urandom_range(8192)) : 31'($urandom),
                           11'($urandom), $urandom_range(1) ? 31'($urandom_range(8192)) :
                           31'($urandom), 13'($urandom));
      endcase
      calm = ph == 4;
      hold_req = ph == 5;
      put_random_records(175);
      if (ph == 7) put_ending();
      drain();
    end

    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
